>>> design/textured_wall_column_draw_core_defines.svh
// ---------------------------------------------------------------------------
// Textured wall column draw core: assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef TEXTURED_WALL_COLUMN_DRAW_CORE_DEFINES_SVH
`define TEXTURED_WALL_COLUMN_DRAW_CORE_DEFINES_SVH

// same-cycle implication
`define TWCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twcd check failed");

// next-cycle implication
`define TWCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twcd check failed");

`endif

>>> design/twcd_pkg.sv
// ---------------------------------------------------------------------------
// twcd_pkg
// Shared constants, codes and controller/datapath structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package twcd_pkg;

  localparam int unsigned SCREEN_HEIGHT_DEF = 64;
  localparam int unsigned TEX_SIZE_DEF      = 64;

  localparam int unsigned TEX_SEL_W  = 2;
  localparam int unsigned BANK_AW    = 12;
  localparam int unsigned STORE_AW   = TEX_SEL_W + BANK_AW;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned COLUMN_W   = 10;
  localparam int unsigned TEXCOL_W   = 6;
  localparam int unsigned SIGN_W     = 2;
  localparam int unsigned ROW_OUT_W  = 6;
  localparam int unsigned LH_W       = 16;

  localparam logic [LH_W-1:0] LH_MAX = '1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  localparam logic [TEX_SEL_W-1:0] TEX_EAST  = 2'd0;
  localparam logic [TEX_SEL_W-1:0] TEX_NORTH = 2'd1;
  localparam logic [TEX_SEL_W-1:0] TEX_SOUTH = 2'd2;
  localparam logic [TEX_SEL_W-1:0] TEX_WEST  = 2'd3;

  typedef struct packed {
    logic load_write;
    logic capture;
    logic div_start;
    logic div_row;
    logic lh_load;
    logic col_setup;
    logic row_init;
    logic row_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic col_empty;
    logic need_step;
    logic out_free;
    logic last_row;
  } status_t;

endpackage

>>> design/twcd_if.sv
// ---------------------------------------------------------------------------
// twcd interfaces
// Valid/ready channels for requests and emitted pixels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface twcd_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [twcd_pkg::TEX_SEL_W-1:0]       load_texture;
  logic [twcd_pkg::BANK_AW-1:0]         load_address;
  logic [twcd_pkg::COLOR_W-1:0]         load_texel;
  logic [twcd_pkg::COLUMN_W-1:0]        screen_column;
  logic [twcd_pkg::DIST_W-1:0]          wall_distance;
  logic [twcd_pkg::TEXCOL_W-1:0]        texture_column;
  logic                                 wall_side;
  logic signed [twcd_pkg::SIGN_W-1:0]   dir_x_sign;
  logic signed [twcd_pkg::SIGN_W-1:0]   dir_y_sign;

  modport source (
    output valid, req_type, load_texture, load_address, load_texel, screen_column,
           wall_distance, texture_column, wall_side, dir_x_sign, dir_y_sign,
    input  ready
  );
  modport sink (
    input  valid, req_type, load_texture, load_address, load_texel, screen_column,
           wall_distance, texture_column, wall_side, dir_x_sign, dir_y_sign,
    output ready
  );
endinterface

interface twcd_pix_if;
  logic                             valid;
  logic                             ready;
  logic [twcd_pkg::COLUMN_W-1:0]    pixel_column;
  logic [twcd_pkg::ROW_OUT_W-1:0]   pixel_row;
  logic [twcd_pkg::COLOR_W-1:0]     pixel_color;
  logic                             last_pixel;

  modport source (
    output valid, pixel_column, pixel_row, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_column, pixel_row, pixel_color, last_pixel,
    output ready
  );
endinterface

>>> design/twcd_div.sv
// ---------------------------------------------------------------------------
// twcd_div
// Restoring divider, one quotient bit per cycle, pulses done at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twcd_div #(
  parameter int unsigned DIVD_W = 23,
  parameter int unsigned DIVS_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIVD_W-1:0] quotient_o,
  output logic [DIVS_W-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DIVS_W-1:0] dvs_q;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              fits;
  logic [DIVS_W-1:0] rem_d;
  logic              last_step;

  assign trial     = {rem_q, quo_q[DIVD_W-1]};
  assign diff      = trial - {1'b0, dvs_q};
  assign fits      = trial >= {1'b0, dvs_q};
  assign rem_d     = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
  assign last_step = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      cnt_q <= CNT_W'(DIVD_W - 1);
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], fits};
      rem_q <= rem_d;
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> design/twcd_datapath.sv
// ---------------------------------------------------------------------------
// twcd_datapath
// Texture store, line height and row bounds, texture row stepping, pixel register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twcd_datapath #(
  parameter int unsigned SCREEN_HEIGHT = twcd_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned TEX_SIZE      = twcd_pkg::TEX_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  twcd_pkg::cmd_t                     cmd_i,
  output twcd_pkg::status_t                  status_o,
  input  logic [twcd_pkg::TEX_SEL_W-1:0]     load_texture_i,
  input  logic [twcd_pkg::BANK_AW-1:0]       load_address_i,
  input  logic [twcd_pkg::COLOR_W-1:0]       load_texel_i,
  input  logic [twcd_pkg::COLUMN_W-1:0]      screen_column_i,
  input  logic [twcd_pkg::DIST_W-1:0]        wall_distance_i,
  input  logic [twcd_pkg::TEXCOL_W-1:0]      texture_column_i,
  input  logic                               wall_side_i,
  input  logic signed [twcd_pkg::SIGN_W-1:0] dir_x_sign_i,
  input  logic signed [twcd_pkg::SIGN_W-1:0] dir_y_sign_i,
  output logic                               pix_valid_o,
  input  logic                               pix_ready_i,
  output logic [twcd_pkg::COLUMN_W-1:0]      pixel_column_o,
  output logic [twcd_pkg::ROW_OUT_W-1:0]     pixel_row_o,
  output logic [twcd_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                               last_pixel_o
);

  localparam int unsigned LH_W       = twcd_pkg::LH_W;
  localparam int unsigned Y_W        = $clog2(SCREEN_HEIGHT);
  localparam int unsigned ROW_W      = $clog2(TEX_SIZE);
  localparam int unsigned REM_W      = LH_W + 1;
  localparam int unsigned DIVD_LH_W  = $clog2(SCREEN_HEIGHT + 1) + LH_W;
  localparam int unsigned DIVD_ROW_W = LH_W + ROW_W - 1;
  localparam int unsigned DIV_W      = (DIVD_LH_W > DIVD_ROW_W) ? DIVD_LH_W : DIVD_ROW_W;
  localparam int unsigned NumWords   = 1 << twcd_pkg::STORE_AW;
  localparam logic [Y_W-1:0]  HalfH  = Y_W'(SCREEN_HEIGHT / 2);
  localparam logic [ROW_W-1:0] RowTop = ROW_W'(TEX_SIZE - 1);

  logic [twcd_pkg::COLOR_W-1:0] mem [NumWords];
  logic [twcd_pkg::COLOR_W-1:0] rd_q;

  logic [twcd_pkg::COLUMN_W-1:0]  col_q;
  logic [twcd_pkg::TEXCOL_W-1:0]  tcol_q;
  logic                           side_q;
  logic [twcd_pkg::SIGN_W-1:0]    dx_q;
  logic [twcd_pkg::SIGN_W-1:0]    dy_q;
  logic [LH_W-1:0]                lh_q;
  logic [Y_W-1:0]                 y_q;
  logic [Y_W-1:0]                 end_q;
  logic [ROW_W-1:0]               row_q;
  logic [REM_W-1:0]               rem_q;
  logic                           sat_q;
  logic [twcd_pkg::TEX_SEL_W-1:0] tex_sel_q;
  logic                           pix_valid_q;
  logic [twcd_pkg::COLUMN_W-1:0]  pix_col_q;
  logic [twcd_pkg::ROW_OUT_W-1:0] pix_row_q;
  logic [twcd_pkg::COLOR_W-1:0]   pix_color_q;
  logic                           pix_last_q;

  logic [LH_W-2:0]                half_lh;
  logic [Y_W-1:0]                 y_start;
  logic [LH_W-1:0]                end_sum;
  logic [Y_W-1:0]                 y_end;
  logic [LH_W:0]                  num0;
  logic [DIV_W-1:0]               n0;
  logic [DIV_W-1:0]               div_dividend;
  logic [twcd_pkg::DIST_W-1:0]    div_divisor;
  logic                           div_done;
  logic [DIV_W-1:0]               div_quo;
  logic [twcd_pkg::DIST_W-1:0]    div_rem;
  logic [LH_W-1:0]                lh_d;
  logic [twcd_pkg::SIGN_W-1:0]    sign_sel;
  logic [twcd_pkg::TEX_SEL_W-1:0] tex_pick;
  logic [ROW_W-1:0]               row_nxt;
  logic [twcd_pkg::BANK_AW-1:0]   tex_addr;
  logic [twcd_pkg::STORE_AW-1:0]  rd_index;
  logic                           last_row;
  logic                           out_free;

  // row bounds from line height
  assign half_lh = lh_q[LH_W-1:1];
  assign y_start = (half_lh >= (LH_W-1)'(SCREEN_HEIGHT / 2)) ? '0
                   : HalfH - Y_W'(half_lh);
  assign end_sum = LH_W'(half_lh) + LH_W'(SCREEN_HEIGHT / 2);
  assign y_end   = (end_sum >= LH_W'(SCREEN_HEIGHT)) ? Y_W'(SCREEN_HEIGHT - 1)
                   : end_sum[Y_W-1:0];

  // numerator of the first row, never negative
  assign num0 = (LH_W+1)'(lh_q) + (LH_W+1)'({y_start, 1'b0}) - (LH_W+1)'(SCREEN_HEIGHT);
  assign n0   = DIV_W'(num0[LH_W-1:0]) << (ROW_W - 1);

  assign div_dividend = cmd_i.div_row ? n0 : (DIV_W'(SCREEN_HEIGHT) << LH_W);
  assign div_divisor  = cmd_i.div_row ? twcd_pkg::DIST_W'(lh_q) : wall_distance_i;

  twcd_div #(
    .DIVD_W(DIV_W),
    .DIVS_W(twcd_pkg::DIST_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign lh_d = (|div_quo[DIV_W-1:LH_W]) ? twcd_pkg::LH_MAX : div_quo[LH_W-1:0];

  // texture choice, zero sign keeps the previous one
  assign sign_sel = side_q ? dy_q : dx_q;
  always_comb begin
    priority if (sign_sel == 2'b01) begin
      tex_pick = side_q ? twcd_pkg::TEX_SOUTH : twcd_pkg::TEX_EAST;
    end else if (sign_sel[1]) begin
      tex_pick = side_q ? twcd_pkg::TEX_WEST : twcd_pkg::TEX_NORTH;
    end else begin
      tex_pick = tex_sel_q;
    end
  end

  assign row_nxt  = row_q + ROW_W'(1);
  assign tex_addr = (twcd_pkg::BANK_AW'(row_q) << ROW_W) + twcd_pkg::BANK_AW'(tcol_q);
  assign rd_index = {tex_sel_q, tex_addr};
  assign last_row = (y_q == (end_q - Y_W'(1)));
  assign out_free = !pix_valid_q || pix_ready_i;

  assign status_o.div_done  = div_done;
  assign status_o.col_empty = (y_start >= y_end);
  assign status_o.need_step = !sat_q && (rem_q >= REM_W'(lh_q));
  assign status_o.out_free  = out_free;
  assign status_o.last_row  = last_row;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write) begin
      mem[{load_texture_i, load_address_i}] <= load_texel_i;
    end
    rd_q <= mem[rd_index];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_sel_q   <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      if (cmd_i.col_setup) begin
        tex_sel_q <= tex_pick;
      end
      if (cmd_i.emit) begin
        pix_valid_q <= 1'b1;
      end else if (pix_ready_i) begin
        pix_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q  <= screen_column_i;
      tcol_q <= texture_column_i;
      side_q <= wall_side_i;
      dx_q   <= dir_x_sign_i;
      dy_q   <= dir_y_sign_i;
    end
    if (cmd_i.lh_load) begin
      lh_q <= lh_d;
    end
    if (cmd_i.col_setup) begin
      y_q   <= y_start;
      end_q <= y_end;
    end
    if (cmd_i.row_init) begin
      rem_q <= REM_W'(div_rem[LH_W-1:0]);
      if (div_quo >= DIV_W'(TEX_SIZE - 1)) begin
        row_q <= RowTop;
        sat_q <= 1'b1;
      end else begin
        row_q <= div_quo[ROW_W-1:0];
        sat_q <= 1'b0;
      end
    end else if (cmd_i.row_step) begin
      rem_q <= rem_q - REM_W'(lh_q);
      row_q <= row_nxt;
      sat_q <= (row_nxt == RowTop);
    end else if (cmd_i.emit && !sat_q) begin
      rem_q <= rem_q + REM_W'(TEX_SIZE);
    end
    if (cmd_i.emit) begin
      y_q         <= y_q + Y_W'(1);
      pix_col_q   <= col_q;
      pix_row_q   <= twcd_pkg::ROW_OUT_W'(y_q);
      pix_color_q <= rd_q;
      pix_last_q  <= last_row;
    end
  end

  assign pix_valid_o    = pix_valid_q;
  assign pixel_column_o = pix_col_q;
  assign pixel_row_o    = pix_row_q;
  assign pixel_color_o  = pix_color_q;
  assign last_pixel_o   = pix_last_q;

endmodule

>>> design/twcd_ctrl.sv
// ---------------------------------------------------------------------------
// twcd_ctrl
// Sequencer: request intake, up to two divisions, row stepping and pixel issue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module twcd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_type_i,
  input  twcd_pkg::status_t status_i,
  output logic              in_ready_o,
  output twcd_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV_LH  = 3'd1;
  localparam logic [2:0] S_BOUNDS  = 3'd2;
  localparam logic [2:0] S_DIV_ROW = 3'd3;
  localparam logic [2:0] S_STEP    = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_type_i == twcd_pkg::REQ_DRAW) begin
            cmd_o.capture   = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV_LH;
          end else begin
            cmd_o.load_write = 1'b1;
          end
        end
      end
      S_DIV_LH: begin
        if (status_i.div_done) begin
          cmd_o.lh_load = 1'b1;
          state_d       = S_BOUNDS;
        end
      end
      S_BOUNDS: begin
        if (status_i.col_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.col_setup = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_row   = 1'b1;
          state_d         = S_DIV_ROW;
        end
      end
      S_DIV_ROW: begin
        if (status_i.div_done) begin
          cmd_o.row_init = 1'b1;
          state_d        = S_STEP;
        end
      end
      S_STEP: begin
        if (status_i.need_step) begin
          cmd_o.row_step = 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.last_row ? S_IDLE : S_STEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/textured_wall_column_draw_core.sv
// Sequence: a load writes its texel at intake and leaves the core ready; a draw runs intake,
//   a line height divider pass, a bounds check and a first row divider pass before pixels.
// Pixels: a step state advances the texture row, at most TEX_SIZE-1 times per column,
//   then an emit state waits for a free output register. Requests wait until a draw ends.
// One restoring divider serves both divisions; the texture memory has one read port.
// Reset: async active low; clears control, divider flags, texture choice, output valid only.
// ---------------------------------------------------------------------------
// textured_wall_column_draw_core
// Textured raycaster wall column: texel loads and per-row pixel generation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module textured_wall_column_draw_core #(
  parameter int unsigned SCREEN_HEIGHT = twcd_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned TEX_SIZE      = twcd_pkg::TEX_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  twcd_req_if.sink    req_i,
  twcd_pix_if.source  pix_o
);

  twcd_pkg::cmd_t    cmd;
  twcd_pkg::status_t status;

  twcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_type_i  (req_i.req_type),
    .status_i   (status),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd)
  );

  twcd_datapath #(
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .TEX_SIZE     (TEX_SIZE)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .load_texture_i   (req_i.load_texture),
    .load_address_i   (req_i.load_address),
    .load_texel_i     (req_i.load_texel),
    .screen_column_i  (req_i.screen_column),
    .wall_distance_i  (req_i.wall_distance),
    .texture_column_i (req_i.texture_column),
    .wall_side_i      (req_i.wall_side),
    .dir_x_sign_i     (req_i.dir_x_sign),
    .dir_y_sign_i     (req_i.dir_y_sign),
    .pix_valid_o      (pix_o.valid),
    .pix_ready_i      (pix_o.ready),
    .pixel_column_o   (pix_o.pixel_column),
    .pixel_row_o      (pix_o.pixel_row),
    .pixel_color_o    (pix_o.pixel_color),
    .last_pixel_o     (pix_o.last_pixel)
  );

endmodule

>>> design/twcd_checker.sv
// ---------------------------------------------------------------------------
// twcd_checker
// Port-level checks on the wall column core, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "textured_wall_column_draw_core_defines.svh"

module twcd_checker #(
  parameter int unsigned SCREEN_HEIGHT = twcd_pkg::SCREEN_HEIGHT_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             req_valid_i,
  input logic                             req_ready_i,
  input logic                             req_type_i,
  input logic                             pix_valid_i,
  input logic                             pix_ready_i,
  input logic [twcd_pkg::COLUMN_W-1:0]    pix_column_i,
  input logic [twcd_pkg::ROW_OUT_W-1:0]   pix_row_i,
  input logic [twcd_pkg::COLOR_W-1:0]     pix_color_i,
  input logic                             pix_last_i
);

  logic req_fire;

  assign req_fire = req_valid_i && req_ready_i;

  `TWCD_ASSERT_NEXT(a_pix_hold, clk_i, rst_ni, pix_valid_i && !pix_ready_i, pix_valid_i && $stable(pix_color_i) && $stable(pix_row_i) && $stable(pix_last_i) && $stable(pix_column_i))
  `TWCD_ASSERT_NOW(a_row_range, clk_i, rst_ni, pix_valid_i, pix_row_i < (SCREEN_HEIGHT - 1))
  `TWCD_ASSERT_NOW(a_busy_mid_column, clk_i, rst_ni, pix_valid_i && !pix_last_i, !req_ready_i)
  `TWCD_ASSERT_NEXT(a_draw_busy, clk_i, rst_ni, req_fire && (req_type_i == twcd_pkg::REQ_DRAW), !req_ready_i)
  `TWCD_ASSERT_NEXT(a_load_ready, clk_i, rst_ni, req_fire && (req_type_i == twcd_pkg::REQ_LOAD), req_ready_i)

endmodule

bind textured_wall_column_draw_core twcd_checker #(
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_twcd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_type_i   (req_i.req_type),
  .pix_valid_i  (pix_o.valid),
  .pix_ready_i  (pix_o.ready),
  .pix_column_i (pix_o.pixel_column),
  .pix_row_i    (pix_o.pixel_row),
  .pix_color_i  (pix_o.pixel_color),
  .pix_last_i   (pix_o.last_pixel)
);
